[rtl/gcb_pkg.sv]
package gcb_pkg;

    // grapheme break property codes
    localparam logic [3:0] CLS_OTHER   = 4'd0;
    localparam logic [3:0] CLS_CR      = 4'd1;
    localparam logic [3:0] CLS_LF      = 4'd2;
    localparam logic [3:0] CLS_CONTROL = 4'd3;
    localparam logic [3:0] CLS_EXTEND  = 4'd4;
    localparam logic [3:0] CLS_ZWJ     = 4'd5;
    localparam logic [3:0] CLS_RI      = 4'd6;
    localparam logic [3:0] CLS_PREPEND = 4'd7;
    localparam logic [3:0] CLS_SPACING = 4'd8;
    localparam logic [3:0] CLS_L       = 4'd9;
    localparam logic [3:0] CLS_V       = 4'd10;
    localparam logic [3:0] CLS_T       = 4'd11;
    localparam logic [3:0] CLS_LV      = 4'd12;
    localparam logic [3:0] CLS_LVT     = 4'd13;

    // utf-8 lead byte thresholds
    localparam logic [7:0] LEAD_2BYTE = 8'h80;
    localparam logic [7:0] LEAD_3BYTE = 8'hE0;
    localparam logic [7:0] LEAD_4BYTE = 8'hF0;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] BYTES_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic [3:0] break_class;
        logic       is_pictographic;
        logic       new_text;
    } gcb_item_t;

    typedef struct packed {
        logic [3:0]  prev_class;
        logic        seen_pict_seq;
        logic        ri_odd;
        logic [31:0] clusters_seen;
        logic [15:0] bytes_in_cluster;
        logic        text_open;
    } gcb_state_t;

endpackage

[rtl/gcb_rules.sv]
module gcb_rules import gcb_pkg::*; (
    input  gcb_item_t  item,
    input  gcb_state_t state,
    output logic       brk,
    output gcb_state_t state_next
);

    logic [3:0]  cur;
    logic [2:0]  len;
    logic        start;
    logic        prev_ctl;
    logic        cur_ctl;
    logic        rule_brk;
    logic [16:0] bytes_sum;

    assign cur      = (item.break_class > CLS_LVT) ? CLS_OTHER : item.break_class;
    assign start    = item.new_text || !state.text_open;
    assign prev_ctl = (state.prev_class == CLS_CR) || (state.prev_class == CLS_LF)
                   || (state.prev_class == CLS_CONTROL);
    assign cur_ctl  = (cur == CLS_CR) || (cur == CLS_LF) || (cur == CLS_CONTROL);

    always_comb begin
        if (item.lead_byte < LEAD_2BYTE) begin
            len = 3'd1;
        end else if (item.lead_byte < LEAD_3BYTE) begin
            len = 3'd2;
        end else if (item.lead_byte < LEAD_4BYTE) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
    end

    // gb3 to gb999, first matching rule wins
    always_comb begin
        priority if (state.prev_class == CLS_CR && cur == CLS_LF) begin
            rule_brk = 1'b0;
        end else if (prev_ctl || cur_ctl) begin
            rule_brk = 1'b1;
        end else if (state.prev_class == CLS_L && (cur == CLS_L || cur == CLS_V
                     || cur == CLS_LV || cur == CLS_LVT)) begin
            rule_brk = 1'b0;
        end else if ((state.prev_class == CLS_LV || state.prev_class == CLS_V)
                     && (cur == CLS_V || cur == CLS_T)) begin
            rule_brk = 1'b0;
        end else if ((state.prev_class == CLS_LVT || state.prev_class == CLS_T)
                     && cur == CLS_T) begin
            rule_brk = 1'b0;
        end else if (cur == CLS_EXTEND || cur == CLS_ZWJ || cur == CLS_SPACING) begin
            rule_brk = 1'b0;
        end else if (state.prev_class == CLS_PREPEND) begin
            rule_brk = 1'b0;
        end else if (state.seen_pict_seq && state.prev_class == CLS_ZWJ
                     && item.is_pictographic) begin
            rule_brk = 1'b0;
        end else if (cur == CLS_RI && state.prev_class == CLS_RI && state.ri_odd) begin
            rule_brk = 1'b0;
        end else begin
            rule_brk = 1'b1;
        end
    end

    assign brk       = start || rule_brk;
    assign bytes_sum = {1'b0, state.bytes_in_cluster} + {14'd0, len};

    always_comb begin
        state_next            = state;
        state_next.text_open  = 1'b1;
        state_next.prev_class = cur;

        // emoji zwj sequence tracking
        if (item.is_pictographic) begin
            state_next.seen_pict_seq = 1'b1;
        end else if (brk) begin
            state_next.seen_pict_seq = 1'b0;
        end else if (cur == CLS_EXTEND) begin
            state_next.seen_pict_seq = state.seen_pict_seq;
        end else if (cur == CLS_ZWJ && state.prev_class != CLS_ZWJ) begin
            state_next.seen_pict_seq = state.seen_pict_seq;
        end else begin
            state_next.seen_pict_seq = 1'b0;
        end

        // regional indicator run parity
        if (cur != CLS_RI) begin
            state_next.ri_odd = 1'b0;
        end else if (!start && state.prev_class == CLS_RI) begin
            state_next.ri_odd = !state.ri_odd;
        end else begin
            state_next.ri_odd = 1'b1;
        end

        if (start) begin
            state_next.clusters_seen = 32'd1;
        end else if (brk && state.clusters_seen != COUNT_MAX) begin
            state_next.clusters_seen = state.clusters_seen + 32'd1;
        end else begin
            state_next.clusters_seen = state.clusters_seen;
        end

        if (brk) begin
            state_next.bytes_in_cluster = {13'd0, len};
        end else if (bytes_sum[16]) begin
            state_next.bytes_in_cluster = BYTES_MAX;
        end else begin
            state_next.bytes_in_cluster = bytes_sum[15:0];
        end
    end

endmodule

[rtl/grapheme_cluster_boundary.sv]
// grapheme cluster boundary detector, one code point per transfer
//
// input channel s_*: utf-8 lead byte, grapheme break class, extended
// pictographic flag and a new-text mark for one code point
// result channel m_*: break-before flag, clusters begun so far in the text
// and byte length of the current cluster, both saturating
//
// a code point taken on s_* lands in the input register, and its result is
// loaded into the output register once that register is empty or drained
// throughput: one code point per cycle while the receiver keeps m_ready
// high, set by the single pass through the rule logic between the input
// register and the output register
//
// reset (aresetn low, synchronous) empties both registers and clears the
// text state; the first code point after reset starts a new text
// when the receiver stalls, the output register holds its result and the
// input register can still take one more code point; s_ready then drops
// until the output is taken
module grapheme_cluster_boundary import gcb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_lead_byte,
    input  logic [3:0]  s_break_class,
    input  logic        s_is_pictographic,
    input  logic        s_new_text,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_break_before,
    output logic [31:0] m_cluster_count,
    output logic [15:0] m_cluster_bytes
);

    gcb_item_t  item_reg;
    logic       in_valid_reg;
    gcb_state_t state_reg;
    gcb_state_t state_next;
    logic       brk;
    logic       out_valid_reg;
    logic       out_brk_reg;
    logic [31:0] out_count_reg;
    logic [15:0] out_bytes_reg;
    logic       advance;
    logic       s_take;

    // input stage moves on when the output register is empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    gcb_rules u_rules (
        .item       (item_reg),
        .state      (state_reg),
        .brk        (brk),
        .state_next (state_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_take) begin
            item_reg.lead_byte       <= s_lead_byte;
            item_reg.break_class     <= s_break_class;
            item_reg.is_pictographic <= s_is_pictographic;
            item_reg.new_text        <= s_new_text;
        end
    end

    // text state, updated once per code point as it leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_brk_reg   <= brk;
            out_count_reg <= state_next.clusters_seen;
            out_bytes_reg <= state_next.bytes_in_cluster;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_break_before  = out_brk_reg;
    assign m_cluster_count = out_count_reg;
    assign m_cluster_bytes = out_bytes_reg;

    // a cluster that has just begun holds only the one code point
    a_break_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_break_before) |->
            (m_cluster_bytes != 16'd0 && m_cluster_bytes <= 16'd4))
        else $error("cluster length wrong at a break");

    // both stages full and receiver stalled: no room for another code point
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted with both stages full");

    // every result belongs to an open text with at least one cluster
    a_text_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg.text_open && m_cluster_count != 32'd0))
        else $error("result without an open text");

    // the rule stage never drops a code point: an advance always yields a result
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result lost after advance");

endmodule
